>>> hw/rtl/kac_pkg.sv
package kac_pkg;

    // Item kinds on the input channel.
    localparam logic [1:0] KIND_KEY    = 2'd0;
    localparam logic [1:0] KIND_TICK   = 2'd1;
    localparam logic [1:0] KIND_REMOTE = 2'd2;

    // Remote command codes.
    localparam logic [2:0] OP_ARM     = 3'd0;
    localparam logic [2:0] OP_DISARM  = 3'd1;
    localparam logic [2:0] OP_SET     = 3'd2;
    localparam logic [2:0] OP_SOUND   = 3'd3;
    localparam logic [2:0] OP_MUTE    = 3'd4;

    // Status message codes.
    localparam logic [2:0] MSG_NONE     = 3'd0;
    localparam logic [2:0] MSG_SET      = 3'd1;
    localparam logic [2:0] MSG_MISMATCH = 3'd2;
    localparam logic [2:0] MSG_INVALID  = 3'd3;
    localparam logic [2:0] MSG_ARMED    = 3'd4;
    localparam logic [2:0] MSG_DISARMED = 3'd5;
    localparam logic [2:0] MSG_SOUNDING = 3'd6;
    localparam logic [2:0] MSG_MUTED    = 3'd7;

    // Code change progress as reported in change_step.
    localparam logic [1:0] CHG_NONE    = 2'd0;
    localparam logic [1:0] CHG_ENTER   = 2'd1;
    localparam logic [1:0] CHG_CONFIRM = 2'd2;

    // Key codes that act on a full entry buffer.
    localparam logic [3:0] KEY_A    = 4'd10;
    localparam logic [3:0] KEY_STAR = 4'd14;

    // Digits carried by a remote set command.
    localparam int REMOTE_DIGITS = 5;

    // Register map: one register, message_duration, at index 0.
    localparam logic        REG_MSG_DURATION = 1'b0;
    localparam logic [15:0] DURATION_RESET   = 16'd3000;
    localparam logic [15:0] TICKS_MAX        = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  key;
        logic        door_open;
        logic [2:0]  remote_op;
        logic [19:0] remote_code;
    } kac_in_t;

    typedef struct packed {
        logic       armed_now;
        logic       siren_on;
        logic [1:0] change_step;
        logic [2:0] entered_count;
        logic [2:0] message_id;
        logic       trigger_event;
    } kac_out_t;

    // Control handed from the pipeline to the state update logic.
    typedef struct packed {
        logic        step;
        logic [15:0] duration;
    } kac_ctrl_t;

endpackage

>>> hw/rtl/kac_core.sv
module kac_core #(
    parameter int CODE_DIGITS = 5
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  kac_pkg::kac_ctrl_t ctrl,
    input  kac_pkg::kac_in_t   item,
    output kac_pkg::kac_out_t  result
);
    import kac_pkg::*;

    localparam int CW = $clog2(CODE_DIGITS + 1);
    localparam int IW = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;

    // Digit 0 is the first digit typed.
    logic [CODE_DIGITS-1:0][3:0] stored_code_reg, stored_code_next;
    logic [CODE_DIGITS-1:0][3:0] entry_buffer_reg;
    logic [CODE_DIGITS-1:0][3:0] first_entry_reg;
    logic [CODE_DIGITS-1:0][3:0] code_load;
    logic [CW-1:0]               entry_count_reg, entry_count_next;
    logic [CW+2:0]               count_wide;
    logic                        held_reg, held_next;
    logic                        changing_reg, changing_next;
    logic                        armed_reg, armed_next;
    logic                        sounding_reg, sounding_next;
    logic [2:0]                  message_reg, message_next;
    logic [15:0]                 ticks_reg, ticks_next;
    logic [15:0]                 ticks_inc;
    logic                        buf_we, first_we, trig;
    logic                        buf_full, entry_match, first_match_ok;

    // Remote set: the first five digits come from the command, the rest are zero.
    for (genvar g = 0; g < CODE_DIGITS; g++) begin : g_load
        if (g < REMOTE_DIGITS) begin : g_from_cmd
            assign code_load[g] = item.remote_code[4*(REMOTE_DIGITS-1-g) +: 4];
        end else begin : g_zero
            assign code_load[g] = 4'd0;
        end
    end

    assign buf_full       = (entry_count_reg == CW'(CODE_DIGITS));
    assign entry_match    = (entry_buffer_reg == stored_code_reg);
    assign first_match_ok = (first_entry_reg == entry_buffer_reg);
    assign ticks_inc      = (ticks_reg == TICKS_MAX) ? ticks_reg : ticks_reg + 16'd1;

    always_comb begin
        stored_code_next = stored_code_reg;
        entry_count_next = entry_count_reg;
        held_next        = held_reg;
        changing_next    = changing_reg;
        armed_next       = armed_reg;
        sounding_next    = sounding_reg;
        message_next     = message_reg;
        ticks_next       = ticks_reg;
        buf_we           = 1'b0;
        first_we         = 1'b0;
        trig             = 1'b0;
        case (item.kind)
            KIND_KEY: begin
                if (message_reg == MSG_NONE) begin
                    if (!buf_full) begin
                        buf_we           = 1'b1;
                        entry_count_next = entry_count_reg + CW'(1);
                    end else begin
                        entry_count_next = '0;
                        if (changing_reg) begin
                            if (!held_reg) begin
                                first_we  = 1'b1;
                                held_next = 1'b1;
                            end else begin
                                if (first_match_ok) begin
                                    stored_code_next = first_entry_reg;
                                    message_next     = MSG_SET;
                                end else begin
                                    message_next = MSG_MISMATCH;
                                end
                                ticks_next    = '0;
                                changing_next = 1'b0;
                                held_next     = 1'b0;
                            end
                        end else if (entry_match) begin
                            if (sounding_reg) begin
                                sounding_next = 1'b0;
                                armed_next    = 1'b0;
                            end else if (item.key == KEY_A) begin
                                armed_next = !armed_reg;
                            end else if (item.key == KEY_STAR) begin
                                changing_next = 1'b1;
                            end
                        end else begin
                            message_next = MSG_INVALID;
                            ticks_next   = '0;
                        end
                    end
                end
            end
            KIND_TICK: begin
                if (message_reg != MSG_NONE) begin
                    if (ticks_inc >= ctrl.duration) begin
                        message_next = MSG_NONE;
                        ticks_next   = '0;
                    end else begin
                        ticks_next = ticks_inc;
                    end
                end
                if (item.door_open && armed_reg && !sounding_reg) begin
                    sounding_next = 1'b1;
                    trig          = 1'b1;
                end
            end
            KIND_REMOTE: begin
                case (item.remote_op)
                    OP_ARM: begin
                        armed_next   = 1'b1;
                        message_next = MSG_ARMED;
                        ticks_next   = '0;
                    end
                    OP_DISARM: begin
                        armed_next   = 1'b0;
                        message_next = MSG_DISARMED;
                        ticks_next   = '0;
                    end
                    OP_SET: begin
                        changing_next    = 1'b0;
                        held_next        = 1'b0;
                        stored_code_next = code_load;
                        message_next     = MSG_SET;
                        ticks_next       = '0;
                    end
                    OP_SOUND: begin
                        sounding_next = 1'b1;
                        message_next  = MSG_SOUNDING;
                        ticks_next    = '0;
                    end
                    OP_MUTE: begin
                        sounding_next = 1'b0;
                        armed_next    = 1'b0;
                        message_next  = MSG_MUTED;
                        ticks_next    = '0;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stored_code_reg <= '0;
            entry_count_reg <= '0;
            held_reg        <= 1'b0;
            changing_reg    <= 1'b0;
            armed_reg       <= 1'b0;
            sounding_reg    <= 1'b0;
            message_reg     <= MSG_NONE;
            ticks_reg       <= '0;
        end else if (ctrl.step) begin
            stored_code_reg <= stored_code_next;
            entry_count_reg <= entry_count_next;
            held_reg        <= held_next;
            changing_reg    <= changing_next;
            armed_reg       <= armed_next;
            sounding_reg    <= sounding_next;
            message_reg     <= message_next;
            ticks_reg       <= ticks_next;
        end
    end

    // The digit buffers are only read where they were written, so they need no reset.
    always_ff @(posedge aclk) begin
        if (ctrl.step && buf_we) begin
            entry_buffer_reg[entry_count_reg[IW-1:0]] <= item.key;
        end
        if (ctrl.step && first_we) begin
            first_entry_reg <= entry_buffer_reg;
        end
    end

    assign count_wide = {3'b000, entry_count_next};

    always_comb begin
        result.armed_now     = armed_next;
        result.siren_on      = sounding_next;
        result.change_step   = !changing_next ? CHG_NONE : (held_next ? CHG_CONFIRM : CHG_ENTER);
        result.entered_count = count_wide[2:0];
        result.message_id    = message_next;
        result.trigger_event = trig;
    end

endmodule

>>> hw/rtl/keypad_alarm_controller_unit.sv
// Keypad alarm controller: one result word for every input word.
// Each accepted word is held in the input register; its state update is made as
// its result enters the result register, which then holds the result word.
// Throughput is one word per cycle while the result channel is not stalled, set by the single state update stage.
// Reset (aresetn, synchronous, active low) clears the pipeline, the flags, the message,
// the entry count and the stored code, and loads message_duration with 3000.
module keypad_alarm_controller_unit #(
    parameter int CODE_DIGITS = 5
) (
    input  logic             aclk,
    input  logic             aresetn,
    // Input channel
    input  logic             s_valid,
    output logic             s_ready,
    input  kac_pkg::kac_in_t s_data,
    // Result channel
    output logic              m_valid,
    input  logic              m_ready,
    output kac_pkg::kac_out_t m_data,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import kac_pkg::*;

    logic      in_vld_reg;
    kac_in_t   in_data_reg;
    logic      out_vld_reg;
    kac_out_t  out_data_reg;
    logic      advance;
    logic      cfg_write;
    logic [15:0] duration_reg;
    kac_ctrl_t core_ctrl;
    kac_out_t  core_result;

    // The result register moves whenever it is empty or being taken. The input
    // register can take a new word whenever its own word moves on, so a stalled
    // result still leaves room for one more word in the input register.
    assign advance = !out_vld_reg || m_ready;
    assign s_ready = !in_vld_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (advance) begin
                out_vld_reg <= in_vld_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance && in_vld_reg) begin
            out_data_reg <= core_result;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_data_reg;

    // Configuration: a write lands on the access cycle. Addresses outside the
    // register map are ignored and read back as zero.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            duration_reg <= DURATION_RESET;
        end else if (cfg_write && (paddr[2] == REG_MSG_DURATION)) begin
            duration_reg <= pwdata[15:0];
        end
    end

    always_comb begin
        case (paddr[2])
            REG_MSG_DURATION: prdata = {16'd0, duration_reg};
            default:          prdata = 32'd0;
        endcase
    end

    // The state update for the word in the input register is committed in the
    // same cycle that its result enters the result register.
    assign core_ctrl.step     = advance && in_vld_reg;
    assign core_ctrl.duration = duration_reg;

    kac_core #(
        .CODE_DIGITS (CODE_DIGITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (core_ctrl),
        .item    (in_data_reg),
        .result  (core_result)
    );

endmodule

>>> hw/rtl/kac_checker.sv
module kac_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input kac_pkg::kac_out_t m_data,
    input logic              pready
);
    import kac_pkg::*;

    // A stalled result word stays put.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // With the result register empty the block always takes a word.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with an empty result register");

    // The door only sets off an armed alarm, which then sounds.
    a_trigger_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.trigger_event |-> m_data.siren_on && m_data.armed_now)
        else $error("trigger reported without armed and sounding alarm");

    // A code change is reported only as enter or confirm.
    a_change_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.change_step == CHG_NONE) || (m_data.change_step == CHG_ENTER)
                    || (m_data.change_step == CHG_CONFIRM))
        else $error("change_step out of range");

    // The configuration port never inserts wait states.
    a_pready_high: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("configuration port stalled");

endmodule

bind keypad_alarm_controller_unit kac_checker u_kac_checker (.*);

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import kac_pkg::*;

    localparam int CODE_DIGITS = 5;

    // The watchdog ends the run after this many cycles in which no word moves on
    // either channel and the configuration port is quiet.
    localparam int QUIET_LIMIT = 4000;

    // A result comes back once its word has passed the input and result registers;
    // this pause leaves slack on top of that before a register write and at the end.
    localparam int DRAIN_CYCLES = 8;

    // Number of random phases, and the counted words each one sends.
    localparam int PHASES = 8;
    localparam int PHASE_WORDS = 195;
    localparam int LONG_PHASE_WORDS = 40;

    // The only register sits at byte address 0.
    localparam logic [2:0] DURATION_ADDR = {REG_MSG_DURATION, 2'b00};

    // Tracks the alarm state word by word and holds the status words that the
    // block still owes on its result channel.
    class alarm_tracker;
        logic [19:0] stored_code;
        logic [19:0] entry_digits;
        logic [19:0] first_digits;
        int unsigned entry_count;
        bit          first_held;
        bit          changing;
        bit          armed;
        bit          sounding;
        logic [2:0]  message;
        int unsigned msg_ticks;
        int unsigned duration;
        kac_out_t    status_due[$];
        int unsigned mismatches;

        function new();
            stored_code  = '0;
            entry_digits = '0;
            first_digits = '0;
            entry_count  = 0;
            first_held   = 1'b0;
            changing     = 1'b0;
            armed        = 1'b0;
            sounding     = 1'b0;
            message      = MSG_NONE;
            msg_ticks    = 0;
            duration     = DURATION_RESET;
            mismatches   = 0;
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t ns: %s", $time, what);
            end
        endfunction

        function void show(logic [2:0] id);
            message   = id;
            msg_ticks = 0;
        endfunction

        function void press(logic [3:0] key);
            if (message != MSG_NONE) begin
                return;
            end
            if (entry_count < CODE_DIGITS) begin
                entry_digits[19 - 4 * entry_count -: 4] = key;
                entry_count++;
                return;
            end
            // A full buffer: this key acts on it and is not stored.
            entry_count = 0;
            if (changing) begin
                if (!first_held) begin
                    first_digits = entry_digits;
                    first_held   = 1'b1;
                end else begin
                    if (first_digits == entry_digits) begin
                        stored_code = first_digits;
                        show(MSG_SET);
                    end else begin
                        show(MSG_MISMATCH);
                    end
                    changing   = 1'b0;
                    first_held = 1'b0;
                end
            end else if (entry_digits == stored_code) begin
                if (sounding) begin
                    sounding = 1'b0;
                    armed    = 1'b0;
                end else if (key == KEY_A) begin
                    armed = !armed;
                end else if (key == KEY_STAR) begin
                    changing = 1'b1;
                end
            end else begin
                show(MSG_INVALID);
            end
        endfunction

        function void remote(logic [2:0] op, logic [19:0] code);
            case (op)
                OP_ARM: begin
                    armed = 1'b1;
                    show(MSG_ARMED);
                end
                OP_DISARM: begin
                    armed = 1'b0;
                    show(MSG_DISARMED);
                end
                OP_SET: begin
                    changing    = 1'b0;
                    first_held  = 1'b0;
                    stored_code = code;
                    show(MSG_SET);
                end
                OP_SOUND: begin
                    sounding = 1'b1;
                    show(MSG_SOUNDING);
                end
                OP_MUTE: begin
                    sounding = 1'b0;
                    armed    = 1'b0;
                    show(MSG_MUTED);
                end
                default: begin
                end
            endcase
        endfunction

        // Applies one accepted input word and queues the status word it causes.
        function void note_word(kac_in_t w);
            kac_out_t status;
            bit       tripped;
            tripped = 1'b0;
            case (w.kind)
                KIND_KEY: press(w.key);
                KIND_TICK: begin
                    if (message != MSG_NONE) begin
                        if (msg_ticks < TICKS_MAX) begin
                            msg_ticks++;
                        end
                        if (msg_ticks >= duration) begin
                            message   = MSG_NONE;
                            msg_ticks = 0;
                        end
                    end
                    if (w.door_open && armed && !sounding) begin
                        sounding = 1'b1;
                        tripped  = 1'b1;
                    end
                end
                KIND_REMOTE: remote(w.remote_op, w.remote_code);
                default: begin
                end
            endcase
            status.armed_now     = armed;
            status.siren_on      = sounding;
            status.change_step   = !changing ? CHG_NONE : (first_held ? CHG_CONFIRM : CHG_ENTER);
            status.entered_count = entry_count[2:0];
            status.message_id    = message;
            status.trigger_event = tripped;
            status_due.push_back(status);
        endfunction

        function void compare_field(string name, logic [2:0] want, logic [2:0] got);
            if (got !== want) begin
                flag($sformatf("%s: expected %0d, got %0d", name, want, got));
            end
        endfunction

        // Compares one result word with the oldest status word still owed.
        function void check_word(kac_out_t got);
            kac_out_t want;
            if (status_due.size() == 0) begin
                flag($sformatf("result word %h arrived with nothing expected", got));
                return;
            end
            want = status_due.pop_front();
            compare_field("armed_now", want.armed_now, got.armed_now);
            compare_field("siren_on", want.siren_on, got.siren_on);
            compare_field("change_step", want.change_step, got.change_step);
            compare_field("entered_count", want.entered_count, got.entered_count);
            compare_field("message_id", want.message_id, got.message_id);
            compare_field("trigger_event", want.trigger_event, got.trigger_event);
        endfunction
    endclass

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    kac_in_t     s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    kac_out_t    m_data;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    // Idling switches for both sides; the last phase turns both off.
    bit send_idle_on = 1'b1;
    bit recv_idle_on = 1'b1;

    // Words that the block acts on. Key words sent while a message is shown are
    // dropped by the block and are not counted here.
    int unsigned counted_words = 0;

    alarm_tracker tracker;

    keypad_alarm_controller_unit #(
        .CODE_DIGITS(CODE_DIGITS)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // The result side drops ready in random bursts. The edge at the top of the loop
    // counts as the last cycle of a burst.
    initial begin
        forever begin
            @(posedge aclk);
            if (recv_idle_on && $urandom_range(0, 9) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(0, 11)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Every result word is checked at the edge that accepts it. Signals read
    // right after the edge still hold the values they had before it.
    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            tracker.check_word(m_data);
        end
    end

    // Watchdog: a long stretch with no traffic at all means the block hung.
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || psel) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("TEST FAILED");
        $finish;
    end

    // Every field gets random content; the builders below fix what matters.
    function automatic kac_in_t random_word();
        logic [31:0] r;
        kac_in_t     w;
        r = $urandom;
        w = r[29:0];
        return w;
    endfunction

    function automatic kac_in_t key_word(input logic [3:0] key);
        kac_in_t w;
        w      = random_word();
        w.kind = KIND_KEY;
        w.key  = key;
        return w;
    endfunction

    function automatic kac_in_t tick_word(input logic door);
        kac_in_t w;
        w           = random_word();
        w.kind      = KIND_TICK;
        w.door_open = door;
        return w;
    endfunction

    function automatic kac_in_t remote_word(input logic [2:0] op, input logic [19:0] code);
        kac_in_t w;
        w             = random_word();
        w.kind        = KIND_REMOTE;
        w.remote_op   = op;
        w.remote_code = code;
        return w;
    endfunction

    // Mostly A and star, which are the keys with a meaning after a full buffer.
    function automatic logic [3:0] acting_key();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 4) begin
            return KEY_A;
        end
        if (r < 7) begin
            return KEY_STAR;
        end
        return 4'($urandom_range(0, 15));
    endfunction

    // Offers one word and holds it until the block takes it. A random gap may
    // come first. The tracker sees the word at the accepting edge.
    task automatic send_word(input kac_in_t w);
        if (send_idle_on && $urandom_range(0, 9) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (!(w.kind == KIND_KEY && tracker.message != MSG_NONE)) begin
            counted_words++;
        end
        tracker.note_word(w);
    endtask

    // Stops sending and waits until every owed status word has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (tracker.status_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic read_register(input logic [2:0] addr, output logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        value = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Writes the message duration with junk in the unused upper half, then
    // reads it back.
    task automatic set_duration(input logic [15:0] value);
        logic [31:0] junk;
        logic [31:0] readback;
        junk = $urandom;
        write_register(DURATION_ADDR, {junk[31:16], value});
        tracker.duration = value;
        read_register(DURATION_ADDR, readback);
        if (readback[15:0] !== value) begin
            tracker.flag($sformatf("message_duration read back %0d, expected %0d",
                                   readback[15:0], value));
        end
    endtask

    task automatic enter_digits(input logic [19:0] digits);
        for (int i = 0; i < CODE_DIGITS; i++) begin
            send_word(key_word(digits[19 - 4 * i -: 4]));
        end
    endtask

    // Ticks until the shown message times out, giving up after 40 ticks so that
    // a long duration does not stall the run.
    task automatic clear_message();
        int unsigned n;
        n = 0;
        while (tracker.message != MSG_NONE && n < 40) begin
            send_word(tick_word($urandom_range(0, 7) == 0));
            n++;
        end
    endtask

    // Brings the keypad to an empty buffer with no message, so that the next
    // five keys form a whole entry.
    task automatic settle();
        int unsigned tries;
        for (tries = 0; tries < 4; tries++) begin
            clear_message();
            if (tracker.entry_count == 0 && tracker.message == MSG_NONE) begin
                break;
            end
            while (tracker.entry_count != 0 && tracker.message == MSG_NONE) begin
                send_word(key_word(4'($urandom_range(0, 15))));
            end
        end
    endtask

    // One random stretch of stimulus. Most of it is whole keypad entries, since
    // only those reach arming, silencing and code changes.
    task automatic run_scenario();
        int unsigned pick;
        int unsigned n;
        logic [19:0] fresh;
        kac_in_t     w;
        pick = $urandom_range(0, 99);
        if (pick < 28) begin
            // The stored code, now and then with one digit wrong, then a key
            // that acts on it.
            settle();
            fresh = tracker.stored_code;
            if ($urandom_range(0, 7) == 0) begin
                n = $urandom_range(0, 4);
                fresh[4 * n +: 4] = fresh[4 * n +: 4] ^ 4'($urandom_range(1, 15));
            end
            enter_digits(fresh);
            send_word(key_word(acting_key()));
        end else if (pick < 43) begin
            // A code change: open it with the stored code and star, then enter
            // the new code twice. Sometimes the second entry differs, and now
            // and then a remote set cuts in between the two entries.
            settle();
            enter_digits(tracker.stored_code);
            send_word(key_word(KEY_STAR));
            fresh = 20'($urandom);
            enter_digits(fresh);
            send_word(key_word(4'($urandom_range(0, 15))));
            if ($urandom_range(0, 9) == 0) begin
                send_word(remote_word(OP_SET, 20'($urandom)));
            end
            if ($urandom_range(0, 3) == 0) begin
                n = $urandom_range(0, 4);
                fresh[4 * n +: 4] = fresh[4 * n +: 4] ^ 4'($urandom_range(1, 15));
            end
            enter_digits(fresh);
            send_word(key_word(4'($urandom_range(0, 15))));
        end else if (pick < 58) begin
            // A remote command; the undefined codes come up now and then.
            if ($urandom_range(0, 15) == 0) begin
                send_word(remote_word(3'($urandom_range(5, 7)), 20'($urandom)));
            end else begin
                send_word(remote_word(3'($urandom_range(0, 4)), 20'($urandom)));
            end
        end else if (pick < 68) begin
            // The door opens.
            send_word(tick_word(1'b1));
        end else if (pick < 78) begin
            n = $urandom_range(1, 6);
            repeat (n) send_word(tick_word($urandom_range(0, 3) == 0));
        end else if (pick < 90) begin
            // Noise: whole random words, with the undefined kind kept rare.
            n = $urandom_range(1, 4);
            repeat (n) begin
                w = random_word();
                if (w.kind == 2'd3 && $urandom_range(0, 3) != 0) begin
                    w.kind = 2'($urandom_range(0, 2));
                end
                send_word(w);
            end
        end else begin
            // A random entry, almost always a wrong code.
            settle();
            enter_digits(20'($urandom));
            send_word(key_word(acting_key()));
        end
    endtask

    initial begin
        logic [31:0] readback;
        logic [15:0] phase_duration [PHASES];
        int unsigned target;

        tracker = new();

        // Durations for the random phases; a zero entry picks a short one at
        // random. The largest register value and 1 are among them.
        phase_duration = '{16'd1, 16'd2, 16'd0, 16'd5, 16'd0, 16'hFFFF, 16'd0, 16'd1};

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        read_register(DURATION_ADDR, readback);
        if (readback[15:0] !== DURATION_RESET) begin
            tracker.flag($sformatf("message_duration after reset is %0d, expected %0d",
                                   readback[15:0], DURATION_RESET));
        end

        // Directed part at the reset duration: a stored key, a remote arm whose
        // message then blocks a key press, the door setting off the alarm, an
        // undefined kind and an undefined remote code, mute, disarm, and a
        // remote set to all ones.
        send_word(key_word(4'd9));
        send_word(remote_word(OP_ARM, 20'h00000));
        send_word(key_word(4'd0));
        send_word(tick_word(1'b1));
        begin
            kac_in_t w;
            w      = random_word();
            w.kind = 2'd3;
            send_word(w);
        end
        send_word(remote_word(3'd7, 20'hFFFFF));
        send_word(remote_word(OP_MUTE, 20'h00000));
        send_word(remote_word(OP_DISARM, 20'h00000));
        send_word(remote_word(OP_SET, 20'hFFFFF));
        drain_results();

        // The shortest duration: each message goes away on the next tick. The
        // entry started above fills up and fails, then the right code with A
        // arms, and after a remote sound the right code with a plain key
        // silences the alarm.
        set_duration(16'd1);
        send_word(tick_word(1'b0));
        enter_digits(20'hFFFF0);
        send_word(key_word(KEY_A));
        send_word(tick_word(1'b0));
        enter_digits(20'hFFFFF);
        send_word(key_word(KEY_A));
        send_word(remote_word(OP_SOUND, 20'h00000));
        send_word(tick_word(1'b0));
        enter_digits(20'hFFFFF);
        send_word(key_word(4'd5));
        send_word(remote_word(OP_SET, 20'h00000));

        // Random phases. Each one starts from an idle block so that the
        // register can be rewritten safely.
        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            if (phase_duration[p] == 16'd0) begin
                set_duration(16'($urandom_range(1, 24)));
            end else begin
                set_duration(phase_duration[p]);
            end
            if (p == PHASES - 1) begin
                send_idle_on = 1'b0;
                recv_idle_on = 1'b0;
            end
            target = counted_words +
                     ((phase_duration[p] == 16'hFFFF) ? LONG_PHASE_WORDS : PHASE_WORDS);
            while (counted_words < target) begin
                run_scenario();
            end
        end

        // Wait for the last results and give any stray word time to show up.
        drain_results();

        if (tracker.mismatches == 0 && tracker.status_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
